/* rtl/cbrs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbrs_pkg
// Item types shared by the chunked base64 record splitter and its users.
// ----------------------------------------------------------------------------
package cbrs_pkg;

    // one input item: a body byte or an end-of-stream flush
    typedef struct packed {
        logic       kind;
        logic [7:0] body_byte;
    } in_item_t;

    // one result item: a decoded data byte or a segment end marker
    typedef struct packed {
        logic        result_kind;
        logic [7:0]  data_byte;
        logic [15:0] segments_so_far;
        logic        framing_error;
        logic        stream_finished;
        logic        last;
    } out_item_t;

    localparam int MAX_RESULTS = 6;
    localparam int RES_IDX_W   = 3;

endpackage
`default_nettype wire

/* rtl/chunked_base64_record_splitter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// chunked_base64_record_splitter
// Parses an HTTP chunked body byte by byte, base64-decodes the chunk data
// and splits the decoded bytes into segments with end markers.
//
// Usage:
//   in_valid/in_ready carry one item per handshake: a body byte (kind 0) or
//   an end-of-stream flush (kind 1). out_valid/out_ready carry result items,
//   one per cycle while out_ready is high; an item's last result has last set.
//   separator_byte (0x0) and max_segment_length (0x4) are written through the
//   APB port while the block is idle; pready is always high.
// Path: an accepted item waits in the input register, then is processed into the
//   result set register; a base64 quartet gives up to six results.
// Throughput: one item per cycle while items give at most one result each
//   and out_ready is high. An item with several results holds the result
//   set register until the output port, which drains one result per cycle,
//   has taken them all; the input register holds one more item meanwhile.
// Reset: parser back to the header phase, decoder, segment length and count
//   cleared, registers to separator 0 and length limit 4096. No clear pass.
// Stall: when out_ready is low the current result holds, the item behind it
//   waits in the input register, and in_ready drops once that is full.
// ----------------------------------------------------------------------------
module chunked_base64_record_splitter
    import cbrs_pkg::*;
#(
    parameter int MAX_SEGMENT_LIMIT = 4096,
    parameter int MAX_HEX_DIGITS    = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int SEG_W = $clog2(MAX_SEGMENT_LIMIT + 1);

    localparam logic [2:0] PH_HEADER    = 3'd0;
    localparam logic [2:0] PH_HEADER_LF = 3'd1;
    localparam logic [2:0] PH_DATA      = 3'd2;
    localparam logic [2:0] PH_TRAIL_CR  = 3'd3;
    localparam logic [2:0] PH_TRAIL_LF  = 3'd4;
    localparam logic [2:0] PH_DONE      = 3'd5;

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [6:0] SX_PAD   = 7'd64;
    localparam logic [6:0] SX_NONE  = 7'd65;
    localparam logic [4:0] HEX_NONE = 5'd16;

    localparam logic       REG_SEPARATOR = 1'b0;
    localparam logic       REG_MAX_LEN   = 1'b1;

    localparam logic       RK_DATA   = 1'b0;
    localparam logic       RK_MARKER = 1'b1;

    typedef struct packed {
        logic [SEG_W-1:0]           seg_len;
        logic [15:0]                seg_cnt;
        logic [RES_IDX_W-1:0]       n;
        out_item_t [MAX_RESULTS-1:0] res;
    } ctx_t;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic ctx_t put_result(ctx_t c, logic kind, logic [7:0] b);
        ctx_t r;
        r = c;
        if (r.n < RES_IDX_W'(MAX_RESULTS))
        begin
            r.res[r.n].result_kind     = kind;
            r.res[r.n].data_byte       = b;
            r.res[r.n].segments_so_far = r.seg_cnt;
            r.res[r.n].framing_error   = 1'b0;
            r.res[r.n].stream_finished = 1'b0;
            r.res[r.n].last            = 1'b0;
            r.n = RES_IDX_W'(r.n + 1'b1);
        end
        return r;
    endfunction

    function automatic ctx_t close_segment(ctx_t c);
        ctx_t r;
        r = c;
        if (r.seg_len != '0)
        begin
            r.seg_cnt = 16'(r.seg_cnt + 16'd1);
            r = put_result(r, RK_MARKER, 8'd0);
        end
        r.seg_len = '0;
        return r;
    endfunction

    function automatic ctx_t take_decoded(ctx_t c, logic [7:0] b, logic [7:0] sep,
                                          logic [SEG_W-1:0] lim);
        ctx_t r;
        r = c;
        if (b == sep)
        begin
            r = close_segment(r);
        end
        else
        begin
            if (r.seg_len >= lim)
            begin
                r = close_segment(r);
            end
            r = put_result(r, RK_DATA, b);
            r.seg_len = SEG_W'(r.seg_len + 1'b1);
        end
        return r;
    endfunction

    // decode what a padded quartet leaves: one byte for two sextets, two for three
    function automatic ctx_t pad_partial(ctx_t c, logic [17:0] store, logic [1:0] cnt,
                                         logic [7:0] sep, logic [SEG_W-1:0] lim);
        ctx_t r;
        r = c;
        if (cnt == 2'd2)
        begin
            r = take_decoded(r, store[11:4], sep, lim);
        end
        else if (cnt == 2'd3)
        begin
            r = take_decoded(r, store[17:10], sep, lim);
            r = take_decoded(r, store[9:2], sep, lim);
        end
        return r;
    endfunction

    function automatic logic [6:0] sextet_of(logic [7:0] ch);
        logic [6:0] s;
        if (ch >= "A" && ch <= "Z")      s = 7'(ch - 8'd65);
        else if (ch >= "a" && ch <= "z") s = 7'(ch - 8'd71);
        else if (ch >= "0" && ch <= "9") s = 7'(ch + 8'd4);
        else if (ch == "+")              s = 7'd62;
        else if (ch == "/")              s = 7'd63;
        else if (ch == "=")              s = SX_PAD;
        else                             s = SX_NONE;
        return s;
    endfunction

    function automatic logic [4:0] hex_value(logic [7:0] ch);
        logic [4:0] h;
        if (ch >= "0" && ch <= "9")      h = 5'(ch - 8'd48);
        else if (ch >= "a" && ch <= "f") h = 5'(ch - 8'd87);
        else if (ch >= "A" && ch <= "F") h = 5'(ch - 8'd55);
        else                             h = HEX_NONE;
        return h;
    endfunction

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic [7:0]              sep_reg;
    logic [12:0]             max_len_reg;
    logic                    in_valid_reg;
    in_item_t                in_reg;
    logic [2:0]              phase_reg, phase_next;
    logic [31:0]             chunk_reg, chunk_next;
    logic [3:0]              hex_cnt_reg, hex_cnt_next;
    logic [17:0]             store_reg, store_next;
    logic [1:0]              sx_cnt_reg, sx_cnt_next;
    logic [SEG_W-1:0]        seg_len_reg;
    logic [15:0]             seg_cnt_reg;
    logic                    err_reg, err_next;
    out_item_t [MAX_RESULTS-1:0] res_reg, res_next;
    logic [RES_IDX_W-1:0]    res_cnt_reg;
    logic [RES_IDX_W-1:0]    res_idx_reg;
    logic                    res_valid_reg;

    logic [SEG_W-1:0]        lim;
    ctx_t                    ctx;
    logic [6:0]              sx;
    logic [4:0]              hx;
    logic [23:0]             quartet;
    logic                    res_pop;
    logic                    res_done;
    logic                    proc;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[2])
            REG_SEPARATOR: prdata = {24'd0, sep_reg};
            REG_MAX_LEN:   prdata = {19'd0, max_len_reg};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg     <= 8'd0;
            max_len_reg <= 13'd4096;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_SEPARATOR)
            begin
                sep_reg <= pwdata[7:0];
            end
            else
            begin
                max_len_reg <= pwdata[12:0];
            end
        end
    end

    // zero acts as one, anything above the build limit acts as the limit
    always_comb
    begin
        if (max_len_reg == 13'd0)
        begin
            lim = SEG_W'(1);
        end
        else if (32'(max_len_reg) > 32'(MAX_SEGMENT_LIMIT))
        begin
            lim = SEG_W'(MAX_SEGMENT_LIMIT);
        end
        else
        begin
            lim = SEG_W'(max_len_reg);
        end
    end

    // ------------------------------------------------------------------
    // item processing
    // ------------------------------------------------------------------
    always_comb
    begin
        ctx          = '0;
        ctx.seg_len  = seg_len_reg;
        ctx.seg_cnt  = seg_cnt_reg;
        phase_next   = phase_reg;
        chunk_next   = chunk_reg;
        hex_cnt_next = hex_cnt_reg;
        store_next   = store_reg;
        sx_cnt_next  = sx_cnt_reg;
        err_next     = err_reg;
        sx           = sextet_of(in_reg.body_byte);
        hx           = hex_value(in_reg.body_byte);
        quartet      = {store_reg, sx[5:0]};

        if (in_reg.kind)
        begin
            ctx         = pad_partial(ctx, store_reg, sx_cnt_reg, sep_reg, lim);
            ctx         = close_segment(ctx);
            store_next  = '0;
            sx_cnt_next = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (in_reg.body_byte == CHAR_CR)
                    begin
                        phase_next = PH_HEADER_LF;
                    end
                    else if (hx != HEX_NONE)
                    begin
                        if (hex_cnt_reg < 4'(MAX_HEX_DIGITS))
                        begin
                            chunk_next   = {chunk_reg[27:0], hx[3:0]};
                            hex_cnt_next = 4'(hex_cnt_reg + 1'b1);
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                end
                PH_HEADER_LF:
                begin
                    if (in_reg.body_byte != CHAR_LF)
                    begin
                        err_next = 1'b1;
                    end
                    hex_cnt_next = '0;
                    phase_next   = (chunk_reg == 32'd0) ? PH_DONE : PH_DATA;
                end
                PH_DATA:
                begin
                    chunk_next = chunk_reg - 32'd1;
                    if (chunk_reg == 32'd1)
                    begin
                        phase_next = PH_TRAIL_CR;
                    end
                    if (sx == SX_PAD)
                    begin
                        ctx         = pad_partial(ctx, store_reg, sx_cnt_reg, sep_reg, lim);
                        store_next  = '0;
                        sx_cnt_next = '0;
                    end
                    else if (sx != SX_NONE)
                    begin
                        if (sx_cnt_reg == 2'd3)
                        begin
                            store_next  = '0;
                            sx_cnt_next = '0;
                            ctx = take_decoded(ctx, quartet[23:16], sep_reg, lim);
                            ctx = take_decoded(ctx, quartet[15:8], sep_reg, lim);
                            ctx = take_decoded(ctx, quartet[7:0], sep_reg, lim);
                        end
                        else
                        begin
                            store_next  = quartet[17:0];
                            sx_cnt_next = 2'(sx_cnt_reg + 1'b1);
                        end
                    end
                end
                PH_TRAIL_CR:
                begin
                    if (in_reg.body_byte != CHAR_CR)
                    begin
                        err_next = 1'b1;
                    end
                    phase_next = PH_TRAIL_LF;
                end
                PH_TRAIL_LF:
                begin
                    if (in_reg.body_byte != CHAR_LF)
                    begin
                        err_next = 1'b1;
                    end
                    phase_next   = PH_HEADER;
                    chunk_next   = '0;
                    hex_cnt_next = '0;
                end
                default:
                begin
                    // stream finished: body bytes are dropped
                end
            endcase
        end
    end

    // status flags reflect the state after the item
    always_comb
    begin
        res_next = ctx.res;
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            res_next[k].framing_error   = err_next;
            res_next[k].stream_finished = (phase_next == PH_DONE);
            res_next[k].last            = (RES_IDX_W'(k + 1) == ctx.n);
        end
    end

    // ------------------------------------------------------------------
    // handshake and pipeline control
    // ------------------------------------------------------------------
    assign res_pop   = res_valid_reg && out_ready;
    assign res_done  = res_pop && (res_idx_reg == RES_IDX_W'(res_cnt_reg - 1'b1));
    assign proc      = in_valid_reg && (!res_valid_reg || res_done);
    assign in_ready  = !in_valid_reg || proc;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg[res_idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            res_idx_reg   <= '0;
            res_cnt_reg   <= '0;
            phase_reg     <= PH_HEADER;
            chunk_reg     <= '0;
            hex_cnt_reg   <= '0;
            store_reg     <= '0;
            sx_cnt_reg    <= '0;
            seg_len_reg   <= '0;
            seg_cnt_reg   <= '0;
            err_reg       <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (proc)
            begin
                res_valid_reg <= (ctx.n != '0);
                res_idx_reg   <= '0;
                res_cnt_reg   <= ctx.n;
                phase_reg     <= phase_next;
                chunk_reg     <= chunk_next;
                hex_cnt_reg   <= hex_cnt_next;
                store_reg     <= store_next;
                sx_cnt_reg    <= sx_cnt_next;
                seg_len_reg   <= ctx.seg_len;
                seg_cnt_reg   <= ctx.seg_cnt;
                err_reg       <= err_next;
            end
            else if (res_done)
            begin
                res_valid_reg <= 1'b0;
            end
            else if (res_pop)
            begin
                res_idx_reg <= RES_IDX_W'(res_idx_reg + 1'b1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_reg <= in_data;
        end
        if (proc)
        begin
            res_reg <= res_next;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_idx_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_idx_reg < res_cnt_reg))
        else $error("result index beyond result count");

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && out_data.last)
            |-> (res_idx_reg == RES_IDX_W'(res_cnt_reg - 1'b1)))
        else $error("last flag not on final result of the set");

    a_count_only_on_proc: assert property (@(posedge clk) disable iff (!rst_n)
        !proc |=> $stable(seg_cnt_reg))
        else $error("segment counter moved without an item");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !out_ready) |=> (res_valid_reg && $stable(res_idx_reg)))
        else $error("stalled result set changed");

endmodule
`default_nettype wire
